// ===== sv/dpt_pkg.sv =====
// shared types, constants and character classes of the path tokenizer
package dpt_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned LenW          = 8;
  localparam int unsigned IndexW        = 31;
  localparam int unsigned MaxNameLenDef = 255;

  localparam logic [CharW-1:0] ChAt     = 8'h40;  // '@'
  localparam logic [CharW-1:0] ChColon  = 8'h3a;  // ':'
  localparam logic [CharW-1:0] ChLbrack = 8'h5b;  // '['
  localparam logic [CharW-1:0] ChRbrack = 8'h5d;  // ']'
  localparam logic [CharW-1:0] ChSlash  = 8'h2f;  // '/'
  localparam logic [CharW-1:0] ChUnder  = 8'h5f;  // '_'
  localparam logic [CharW-1:0] ChDot    = 8'h2e;  // '.'

  typedef enum logic [2:0] {
    PS_START       = 3'd0,
    PS_START_EL    = 3'd1,
    PS_CONT_EL     = 3'd2,
    PS_START_ARRAY = 3'd3,
    PS_END_ARRAY   = 3'd4,
    PS_START_ATTR  = 3'd5,
    PS_CONT_ATTR   = 3'd6
  } parse_state_e;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TK_ELEMENT = 2'd0,
    TK_ARRAY   = 2'd1,
    TK_ATTR    = 2'd2
  } token_kind_e;

  typedef struct packed {
    parse_state_e      parse_state;
    logic              prefix_seen;
    logic [LenW-1:0]   prefix_count;
    logic [LenW-1:0]   token_count;
    logic [IndexW-1:0] index_acc;
    logic              digit_seen;
    logic              error_seen;
  } dpt_state_t;

  typedef struct packed {
    status_e           status;
    logic              token_ready;
    token_kind_e       token_kind;
    logic              prefix_present;
    logic [LenW-1:0]   prefix_length;
    logic [LenW-1:0]   name_length;
    logic              index_present;
    logic [IndexW-1:0] index_value;
  } dpt_result_t;

  localparam dpt_state_t StateReset = '{
    parse_state:  PS_START,
    prefix_seen:  1'b0,
    prefix_count: '0,
    token_count:  '0,
    index_acc:    '0,
    digit_seen:   1'b0,
    error_seen:   1'b0
  };

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_start(input logic [CharW-1:0] c);
    return is_letter(c) || (c == ChUnder);
  endfunction

  function automatic logic is_name_char(input logic [CharW-1:0] c);
    return is_letter(c) || is_digit(c) || (c == ChUnder) || (c == ChDot);
  endfunction

endpackage

// ===== sv/dpt_if.sv =====
// request channels of the path tokenizer: characters in, tokens out
interface dpt_in_if
  import dpt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface dpt_out_if
  import dpt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              token_ready;
  logic [1:0]        token_kind;
  logic              prefix_present;
  logic [LenW-1:0]   prefix_length;
  logic [LenW-1:0]   name_length;
  logic              index_present;
  logic [IndexW-1:0] index_value;

  modport source (
    output valid, output status, output token_ready, output token_kind,
    output prefix_present, output prefix_length, output name_length,
    output index_present, output index_value, input ready
  );
  modport sink (
    input valid, input status, input token_ready, input token_kind,
    input prefix_present, input prefix_length, input name_length,
    input index_present, input index_value, output ready
  );
endinterface

// ===== sv/dpt_next.sv =====
// path dfa: next parser state and token result for one character
module dpt_next
  import dpt_pkg::*;
#(
  parameter int unsigned MaxNameLen = MaxNameLenDef
) (
  input  dpt_state_t       state_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  output dpt_state_t       state_o,
  output dpt_result_t      result_o
);

  localparam int unsigned     NameLimit  = (MaxNameLen < 255) ? MaxNameLen : 255;
  localparam logic [LenW-1:0] NameLimitL = LenW'(NameLimit);

  dpt_state_t        st;
  dpt_result_t       res;
  parse_state_e      s_eff;
  logic [IndexW+3:0] acc_x10;
  logic [IndexW+3:0] acc_new;

  assign acc_x10 = (IndexW+4)'({state_i.index_acc, 3'b000})
                 + (IndexW+4)'({state_i.index_acc, 1'b0});
  assign acc_new = acc_x10 + (IndexW+4)'(char_i[3:0]);

  always_comb begin
    st    = state_i;
    res   = '0;
    s_eff = (state_i.parse_state == PS_START) ? PS_START_EL : state_i.parse_state;

    if (!state_i.error_seen) begin
      if ((state_i.parse_state == PS_START) && (char_i == ChAt)) begin
        st.parse_state = PS_START_ATTR;
      end else begin
        unique case (s_eff)
          PS_START_EL, PS_START_ATTR: begin
            if (is_name_start(char_i)) begin
              st.token_count = LenW'(1);
              st.parse_state = (s_eff == PS_START_EL) ? PS_CONT_EL : PS_CONT_ATTR;
            end else begin
              st.error_seen = 1'b1;
            end
          end
          PS_CONT_EL, PS_CONT_ATTR: begin
            if (is_name_char(char_i)) begin
              if (state_i.token_count >= NameLimitL) st.error_seen = 1'b1;
              else st.token_count = state_i.token_count + LenW'(1);
            end else if ((char_i == ChColon) && !state_i.prefix_seen) begin
              st.prefix_seen  = 1'b1;
              st.prefix_count = state_i.token_count;
              st.token_count  = '0;
              st.parse_state  = (s_eff == PS_CONT_EL) ? PS_START_EL : PS_START_ATTR;
            end else if ((s_eff == PS_CONT_EL) && (char_i == ChLbrack)) begin
              st.index_acc   = '0;
              st.digit_seen  = 1'b0;
              st.parse_state = PS_START_ARRAY;
            end else if ((s_eff == PS_CONT_EL) && (char_i == ChSlash)) begin
              res.token_ready    = 1'b1;
              res.token_kind     = TK_ELEMENT;
              res.prefix_present = state_i.prefix_seen;
              res.prefix_length  = state_i.prefix_count;
              res.name_length    = state_i.token_count;
              st                 = StateReset;
            end else begin
              st.error_seen = 1'b1;
            end
          end
          PS_START_ARRAY: begin
            if (char_i == ChRbrack) begin
              res.token_ready    = 1'b1;
              res.token_kind     = TK_ARRAY;
              res.prefix_present = state_i.prefix_seen;
              res.prefix_length  = state_i.prefix_count;
              res.name_length    = state_i.token_count;
              res.index_present  = state_i.digit_seen;
              res.index_value    = state_i.digit_seen ? state_i.index_acc : '0;
              st.parse_state     = PS_END_ARRAY;
            end else if (is_digit(char_i)) begin
              if (|acc_new[IndexW+3:IndexW]) begin
                st.error_seen = 1'b1;
              end else begin
                st.index_acc  = acc_new[IndexW-1:0];
                st.digit_seen = 1'b1;
              end
            end else begin
              st.error_seen = 1'b1;
            end
          end
          PS_END_ARRAY: begin
            if (char_i == ChSlash) st = StateReset;
            else st.error_seen = 1'b1;
          end
          default: st.error_seen = 1'b1;
        endcase
      end
    end

    if (last_i) begin
      if (st.error_seen) begin
        res.status = ST_INVALID;
      end else if (st.parse_state == PS_CONT_EL || st.parse_state == PS_CONT_ATTR) begin
        res.status         = ST_ACCEPT;
        res.token_ready    = 1'b1;
        res.token_kind     = (st.parse_state == PS_CONT_EL) ? TK_ELEMENT : TK_ATTR;
        res.prefix_present = st.prefix_seen;
        res.prefix_length  = st.prefix_count;
        res.name_length    = st.token_count;
        res.index_present  = 1'b0;
        res.index_value    = '0;
      end else if (st.parse_state == PS_END_ARRAY) begin
        res.status = ST_ACCEPT;
      end else begin
        res.status = ST_INVALID;
      end
      st = StateReset;
    end
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

// ===== sv/dom_path_tokenizer.sv =====
// top level of the path tokenizer: input register, dfa step, result register
// an accepted character passes the input register, then the result register, before its result is valid
// throughput: one character per cycle while the output is not stalled, set by the combinational dfa step in dpt_next
// backpressure: while a result waits, the input register takes one more request, then stalls
// reset: rst_ni clears both valid flags and returns the parser to its start state
// the parser state also returns to start after every character flagged last
module dom_path_tokenizer
  import dpt_pkg::*;
#(
  parameter int unsigned MaxNameLen = MaxNameLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpt_in_if.sink    in_i,
  dpt_out_if.source out_o
);

  // input register stage
  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // parser state and result register
  dpt_state_t  state_q, state_d;
  dpt_result_t res_q, res_d;
  logic        out_vld_q;

  // the result register can take a new value when empty or being drained
  logic advance;
  assign advance    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.character;
      in_last_q <= in_i.last;
    end
  end

  // one dfa transition per registered character
  dpt_next #(
    .MaxNameLen (MaxNameLen)
  ) u_next (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // parser state only moves when the character's result is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateReset;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  // result request
  assign out_o.valid          = out_vld_q;
  assign out_o.status         = res_q.status;
  assign out_o.token_ready    = res_q.token_ready;
  assign out_o.token_kind     = res_q.token_kind;
  assign out_o.prefix_present = res_q.prefix_present;
  assign out_o.prefix_length  = res_q.prefix_length;
  assign out_o.name_length    = res_q.name_length;
  assign out_o.index_present  = res_q.index_present;
  assign out_o.index_value    = res_q.index_value;

endmodule

// ===== sv/dpt_checker.sv =====
// port-level checks of the path tokenizer, bound to the top level
module dpt_checker
  import dpt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [1:0]        status_i,
  input logic              token_ready_i,
  input logic [1:0]        token_kind_i,
  input logic              prefix_present_i,
  input logic [LenW-1:0]   prefix_length_i,
  input logic [LenW-1:0]   name_length_i,
  input logic              index_present_i,
  input logic [IndexW-1:0] index_value_i
);

  // no token means all token fields are clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !token_ready_i) |->
      (token_kind_i == TK_ELEMENT) && !prefix_present_i && (prefix_length_i == '0)
      && (name_length_i == '0) && !index_present_i && (index_value_i == '0))
    else $error("token fields set without a token");

  // only array elements carry an index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && index_present_i) |-> (token_kind_i == TK_ARRAY))
    else $error("index on a non-array token");

  // prefix length only with a prefix, index value only with an index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (!prefix_present_i || !index_present_i)) |->
      ((prefix_present_i || (prefix_length_i == '0))
       && (index_present_i || (index_value_i == '0))))
    else $error("length or index without its present flag");

  // status is never the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_CONTINUE || status_i == ST_ACCEPT
                     || status_i == ST_INVALID))
    else $error("unused status code");

  // a stalled result holds its valid, status, token flag, name length and index value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(token_ready_i)
       && $stable(name_length_i) && $stable(index_value_i)))
    else $error("stalled result changed");

endmodule

bind dom_path_tokenizer dpt_checker u_dpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .token_ready_i    (out_o.token_ready),
  .token_kind_i     (out_o.token_kind),
  .prefix_present_i (out_o.prefix_present),
  .prefix_length_i  (out_o.prefix_length),
  .name_length_i    (out_o.name_length),
  .index_present_i  (out_o.index_present),
  .index_value_i    (out_o.index_value)
);
